@@ rtl/wsh_pkg.sv @@
// Package for the weighted size histogram.
// Holds the item structs, request and register codes, widths and defaults.
// No dependencies.
package wsh_pkg;

   localparam int CNT_W   = 32;
   localparam int SUM_W   = 48;
   localparam int SIZE_W  = 20;
   localparam int IDX_W   = 12;
   localparam int EDGE_W  = 16;
   localparam int COARSE_BINS = 5;
   localparam int CIDX_W  = 3;

   localparam int FINE_BINS_DEF      = 4096;
   localparam int OVERFLOW_LIMIT_DEF = 4094;

   localparam logic [EDGE_W-1:0] MID_EDGE_RST  = 16'd10;
   localparam logic [EDGE_W-1:0] HIGH_EDGE_RST = 16'd100;

   localparam logic [1:0] REQ_ADD         = 2'd0;
   localparam logic [1:0] REQ_READ_FINE   = 2'd1;
   localparam logic [1:0] REQ_READ_COARSE = 2'd2;

   localparam logic CSR_MID_EDGE  = 1'b0;
   localparam logic CSR_HIGH_EDGE = 1'b1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SIZE_W-1:0] cluster_size;
      logic [IDX_W-1:0]  bin_index;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] bin_count;
      logic [SUM_W-1:0] bin_atoms;
      logic [CNT_W-1:0] total_count;
      logic [SUM_W-1:0] total_atoms;
   } rsp_item_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [SIZE_W-1:0] v);
      logic [SUM_W:0] r;
      r = {1'b0, s} + (SUM_W+1)'(v);
      sat_add = r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
   endfunction

endpackage

@@ rtl/weighted_size_histogram.sv @@
// Top level of the weighted size histogram: fine bin memory, coarse bins, totals.
// Depends on wsh_pkg.
//
// After reset the block sweeps all FINE_BINS entries of the fine bin memory to zero,
// one entry per cycle, and takes no item meanwhile (register writes are taken).
// Each item then passes through ST_IDLE and ST_LOOKUP: the fine memory is read on
// acceptance and the updated entry is written back once the output register is
// free, so one item is in flight and no new item is taken until the last one has
// finished. A finished result waits in the output register while the next item is
// taken. Coarse bins and totals live in flip-flops and update with the write back.
module weighted_size_histogram
   import wsh_pkg::*;
#(
   parameter int FINE_BINS      = FINE_BINS_DEF,
   parameter int OVERFLOW_LIMIT = OVERFLOW_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_item_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_item_type      rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [EDGE_W-1:0] csr_wdata
);

   localparam int AW = $clog2(FINE_BINS);
   localparam int MW = CNT_W + SUM_W;
   localparam logic [SIZE_W-1:0] OVF_LIMIT = SIZE_W'(OVERFLOW_LIMIT);
   localparam logic [SIZE_W-1:0] OVF_BIN   = SIZE_W'(OVERFLOW_LIMIT + 1);
   localparam logic [SIZE_W:0]   FINE_LIM  = (SIZE_W+1)'(FINE_BINS);
   localparam logic [AW-1:0]     LAST_BIN  = AW'(FINE_BINS - 1);

   state_type state_ff, state_in;

   logic [MW-1:0] mem [FINE_BINS];
   logic [MW-1:0] mem_q_ff;
   logic          mem_re;
   logic          mem_we;
   logic [AW-1:0] mem_raddr;
   logic [AW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;

   logic [AW-1:0] clr_cnt_ff, clr_cnt_in;
   req_item_type  item_ff;
   logic [AW-1:0] item_addr_ff;
   logic          fine_ok_ff;

   logic [CNT_W-1:0] coarse_cnt_ff [COARSE_BINS];
   logic [SUM_W-1:0] coarse_atm_ff [COARSE_BINS];
   logic [CNT_W-1:0] total_cnt_ff, total_cnt_in;
   logic [SUM_W-1:0] total_atm_ff, total_atm_in;
   logic [EDGE_W-1:0] mid_edge_ff, high_edge_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              finish;
   logic [SIZE_W-1:0] fb;
   logic [AW-1:0]     add_addr;
   logic [SIZE_W-1:0] idx_ext;
   logic              idx_in_range;

   logic [CNT_W-1:0]  fine_cnt_new;
   logic [SUM_W-1:0]  fine_atm_new;
   logic              is_add;
   logic              cb_hit;
   logic [CIDX_W-1:0] cb;
   logic [CIDX_W-1:0] cidx;
   logic [CNT_W-1:0]  coarse_cnt_rd;
   logic [SUM_W-1:0]  coarse_atm_rd;

   assign accept = req_valid && req_ready;
   assign finish = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   // fine bin of an add, clamped into the memory, and the read address of the item
   always_comb begin
      fb = (req_data.cluster_size > OVF_LIMIT) ? OVF_BIN : req_data.cluster_size;
      if ({1'b0, fb} >= FINE_LIM) begin
         add_addr = LAST_BIN;
      end else begin
         add_addr = fb[AW-1:0];
      end
      idx_ext      = SIZE_W'(req_data.bin_index);
      idx_in_range = {1'b0, idx_ext} < FINE_LIM;
      mem_raddr    = (req_data.req_type == REQ_ADD) ? add_addr : idx_ext[AW-1:0];
   end

   // next state
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_BIN) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_ready = 1'b0;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = item_addr_ff;
      mem_wdata = {fine_cnt_new, fine_atm_new};
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            mem_re    = req_valid;
         end
         ST_LOOKUP: begin
            mem_we = finish && is_add;
         end
         default: ;
      endcase
   end

   // update and result
   always_comb begin
      is_add       = item_ff.req_type == REQ_ADD;
      fine_cnt_new = sat_inc(mem_q_ff[MW-1:SUM_W]);
      fine_atm_new = sat_add(mem_q_ff[SUM_W-1:0], item_ff.cluster_size);

      cb_hit = 1'b1;
      cb     = CIDX_W'(4);
      if (item_ff.cluster_size == '0) begin
         cb_hit = 1'b0;
      end else if (item_ff.cluster_size == SIZE_W'(1)) begin
         cb = CIDX_W'(0);
      end else if (item_ff.cluster_size == SIZE_W'(2)) begin
         cb = CIDX_W'(1);
      end else if (item_ff.cluster_size <= SIZE_W'(mid_edge_ff)) begin
         cb = CIDX_W'(2);
      end else if (item_ff.cluster_size <= SIZE_W'(high_edge_ff)) begin
         cb = CIDX_W'(3);
      end

      cidx = is_add ? cb : item_ff.bin_index[CIDX_W-1:0];
      coarse_cnt_rd = '0;
      coarse_atm_rd = '0;
      if (cidx < CIDX_W'(COARSE_BINS)) begin
         coarse_cnt_rd = coarse_cnt_ff[cidx];
         coarse_atm_rd = coarse_atm_ff[cidx];
      end

      total_cnt_in = total_cnt_ff;
      total_atm_in = total_atm_ff;
      if (finish && is_add) begin
         total_cnt_in = sat_inc(total_cnt_ff);
         total_atm_in = sat_add(total_atm_ff, item_ff.cluster_size);
      end

      rsp_data_in             = rsp_data_ff;
      if (finish) begin
         rsp_data_in.bin_count   = '0;
         rsp_data_in.bin_atoms   = '0;
         rsp_data_in.total_count = total_cnt_in;
         rsp_data_in.total_atoms = total_atm_in;
         case (item_ff.req_type)
            REQ_ADD: begin
               rsp_data_in.bin_count = fine_cnt_new;
               rsp_data_in.bin_atoms = fine_atm_new;
            end
            REQ_READ_FINE: begin
               if (fine_ok_ff) begin
                  rsp_data_in.bin_count = mem_q_ff[MW-1:SUM_W];
                  rsp_data_in.bin_atoms = mem_q_ff[SUM_W-1:0];
               end
            end
            REQ_READ_COARSE: begin
               if (item_ff.bin_index < IDX_W'(COARSE_BINS)) begin
                  rsp_data_in.bin_count = coarse_cnt_rd;
                  rsp_data_in.bin_atoms = coarse_atm_rd;
               end
            end
            default: ;
         endcase
      end

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff      <= req_data;
         item_addr_ff <= add_addr;
         fine_ok_ff   <= idx_in_range;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         total_cnt_ff <= '0;
         total_atm_ff <= '0;
         mid_edge_ff  <= MID_EDGE_RST;
         high_edge_ff <= HIGH_EDGE_RST;
         for (int i = 0; i < COARSE_BINS; i++) begin
            coarse_cnt_ff[i] <= '0;
            coarse_atm_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         total_cnt_ff <= total_cnt_in;
         total_atm_ff <= total_atm_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MID_EDGE:  mid_edge_ff  <= csr_wdata;
               CSR_HIGH_EDGE: high_edge_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (finish && is_add && cb_hit) begin
            coarse_cnt_ff[cb] <= sat_inc(coarse_cnt_rd);
            coarse_atm_ff[cb] <= sat_add(coarse_atm_rd, item_ff.cluster_size);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/wsh_checker.sv @@
// Port-level checker for weighted_size_histogram, with its bind statement.
// Depends on wsh_pkg.
module wsh_checker
   import wsh_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_item_type rsp_data
);

   logic [2:0]       pend_ff;
   logic [CNT_W-1:0] last_cnt_ff;
   logic [SUM_W-1:0] last_atm_ff;
   logic             req_acc;
   logic             rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff     <= '0;
         last_cnt_ff <= '0;
         last_atm_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 3'(req_acc) - 3'(rsp_acc);
         if (rsp_acc) begin
            last_cnt_ff <= rsp_data.total_count;
            last_atm_ff <= rsp_data.total_atoms;
         end
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped before acceptance");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("stalled rsp item changed");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 3'd0)
      else $error("rsp item without a request");

   a_totals_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> rsp_data.total_count >= last_cnt_ff &&
                  rsp_data.total_atoms >= last_atm_ff)
      else $error("totals went backward");

endmodule

bind weighted_size_histogram wsh_checker u_wsh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/sv/weighted_size_histogram_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for weighted_size_histogram: valid/ready stimulus, random stalls,
// edge register sweeps and a scoreboard class that predicts every result item.
// Depends on wsh_pkg and the weighted_size_histogram RTL.
module weighted_size_histogram_tb;
   import wsh_pkg::*;

   localparam logic [1:0] REQ_NOP = 2'd3;
   localparam int SIZE_MAX = (1 << SIZE_W) - 1;
   localparam int IDX_MAX = (1 << IDX_W) - 1;
   localparam int SEG_ITEMS = 270;
   localparam int LIMIT_CYCLES = 300000;

   class histogram_scoreboard;
      logic [CNT_W-1:0] fine_cnt [FINE_BINS_DEF];
      logic [SUM_W-1:0] fine_sum [FINE_BINS_DEF];
      logic [CNT_W-1:0] coarse_cnt [COARSE_BINS];
      logic [SUM_W-1:0] coarse_sum [COARSE_BINS];
      logic [CNT_W-1:0] total_cnt;
      logic [SUM_W-1:0] total_sum;
      logic [EDGE_W-1:0] mid_edge;
      logic [EDGE_W-1:0] high_edge;
      rsp_item_type owed_rsp_q [$];
      int unsigned fail_count;

      function new();
         foreach (fine_cnt[i]) begin
            fine_cnt[i] = '0;
            fine_sum[i] = '0;
         end
         foreach (coarse_cnt[i]) begin
            coarse_cnt[i] = '0;
            coarse_sum[i] = '0;
         end
         total_cnt = '0;
         total_sum = '0;
         mid_edge = MID_EDGE_RST;
         high_edge = HIGH_EDGE_RST;
         fail_count = 0;
      endfunction

      function void set_edge(logic idx, logic [EDGE_W-1:0] value);
         if (idx == CSR_MID_EDGE) begin
            mid_edge = value;
         end else begin
            high_edge = value;
         end
      endfunction

      function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
         return (&c) ? c : c + 1'b1;
      endfunction

      function logic [SUM_W-1:0] accumulate(logic [SUM_W-1:0] s, logic [SIZE_W-1:0] v);
         logic [63:0] wide;
         wide = 64'(s) + 64'(v);
         return (wide > 64'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type res;
         int fb;
         int cb;
         res = '0;
         case (r.req_type)
            REQ_ADD: begin
               fb = (r.cluster_size > OVERFLOW_LIMIT_DEF) ? OVERFLOW_LIMIT_DEF + 1
                                                          : int'(r.cluster_size);
               if (fb >= FINE_BINS_DEF) fb = FINE_BINS_DEF - 1;
               fine_cnt[fb] = bump(fine_cnt[fb]);
               fine_sum[fb] = accumulate(fine_sum[fb], r.cluster_size);
               res.bin_count = fine_cnt[fb];
               res.bin_atoms = fine_sum[fb];
               if (r.cluster_size == 0) cb = -1;
               else if (r.cluster_size == 1) cb = 0;
               else if (r.cluster_size == 2) cb = 1;
               else if (r.cluster_size <= mid_edge) cb = 2;
               else if (r.cluster_size <= high_edge) cb = 3;
               else cb = 4;
               if (cb >= 0) begin
                  coarse_cnt[cb] = bump(coarse_cnt[cb]);
                  coarse_sum[cb] = accumulate(coarse_sum[cb], r.cluster_size);
               end
               total_cnt = bump(total_cnt);
               total_sum = accumulate(total_sum, r.cluster_size);
            end
            REQ_READ_FINE: begin
               if (r.bin_index < FINE_BINS_DEF) begin
                  res.bin_count = fine_cnt[r.bin_index];
                  res.bin_atoms = fine_sum[r.bin_index];
               end
            end
            REQ_READ_COARSE: begin
               if (r.bin_index < COARSE_BINS) begin
                  res.bin_count = coarse_cnt[r.bin_index];
                  res.bin_atoms = coarse_sum[r.bin_index];
               end
            end
            default: ;
         endcase
         res.total_count = total_cnt;
         res.total_atoms = total_sum;
         owed_rsp_q.push_back(res);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (owed_rsp_q.size() == 0) begin
            $error("result item with no request outstanding: %p", got);
            fail_count++;
            return;
         end
         want = owed_rsp_q.pop_front();
         compare_field("bin_count", 64'(want.bin_count), 64'(got.bin_count));
         compare_field("bin_atoms", 64'(want.bin_atoms), 64'(got.bin_atoms));
         compare_field("total_count", 64'(want.total_count), 64'(got.total_count));
         compare_field("total_atoms", 64'(want.total_atoms), 64'(got.total_atoms));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_item_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_MID_EDGE;
   logic [EDGE_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int unsigned cycle_count = 0;
   histogram_scoreboard sb = new();

   weighted_size_histogram dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4ns clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $error("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_item_type mk(logic [1:0] t, int size, int idx);
      req_item_type r;
      r.req_type = t;
      r.cluster_size = SIZE_W'(size);
      r.bin_index = IDX_W'(idx);
      return r;
   endfunction

   function automatic logic [SIZE_W-1:0] near(int center);
      int v;
      v = center - 2 + int'($urandom_range(4));
      if (v < 0) v = 0;
      if (v > SIZE_MAX) v = SIZE_MAX;
      return SIZE_W'(v);
   endfunction

   task automatic send_item(req_item_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(item);
   endtask

   task automatic wait_drained();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.owed_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_edge(logic idx, logic [EDGE_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      sb.set_edge(idx, value);
   endtask

   initial begin
      req_item_type item;
      logic [EDGE_W-1:0] mid_cfg;
      logic [EDGE_W-1:0] high_cfg;
      int n_random;
      int pick;

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      for (int seg = 0; seg < 6; seg++) begin
         wait_drained();
         case (seg)
            0: begin mid_cfg = 16'd10;    high_cfg = 16'd100;   end
            1: begin mid_cfg = 16'd3;     high_cfg = 16'd4;     end
            2: begin mid_cfg = 16'hFFFF;  high_cfg = 16'hFFFF;  end
            3: begin mid_cfg = 16'd300;   high_cfg = 16'd40;    end
            4: begin mid_cfg = 16'd0;     high_cfg = 16'd0;     end
            default: begin
               mid_cfg = EDGE_W'($urandom_range(3, 500));
               high_cfg = mid_cfg + EDGE_W'($urandom_range(1, 2000));
            end
         endcase
         write_edge(CSR_MID_EDGE, mid_cfg);
         write_edge(CSR_HIGH_EDGE, high_cfg);
         send_idle_pct = (seg < 2) ? 27 : (seg < 4) ? 79 : 0;
         recv_idle_pct = (seg < 2) ? 79 : (seg < 4) ? 27 : 0;
         n_random = SEG_ITEMS;

         if (seg == 0) begin
            // size boundaries, coarse edges, overflow bin, all reads and the unused opcode
            send_item(mk(REQ_ADD, 0, 0));
            send_item(mk(REQ_ADD, 1, 0));
            send_item(mk(REQ_ADD, 2, 0));
            send_item(mk(REQ_ADD, 10, 0));
            send_item(mk(REQ_ADD, 11, 0));
            send_item(mk(REQ_ADD, 100, 0));
            send_item(mk(REQ_ADD, 101, 0));
            send_item(mk(REQ_ADD, OVERFLOW_LIMIT_DEF, 0));
            send_item(mk(REQ_ADD, OVERFLOW_LIMIT_DEF + 1, 0));
            send_item(mk(REQ_ADD, SIZE_MAX, IDX_MAX));
            send_item(mk(REQ_READ_FINE, 0, 0));
            send_item(mk(REQ_READ_FINE, SIZE_MAX, 1));
            send_item(mk(REQ_READ_FINE, 0, 10));
            send_item(mk(REQ_READ_FINE, 0, OVERFLOW_LIMIT_DEF));
            send_item(mk(REQ_READ_FINE, 0, OVERFLOW_LIMIT_DEF + 1));
            for (int b = 0; b < COARSE_BINS; b++) send_item(mk(REQ_READ_COARSE, 0, b));
            send_item(mk(REQ_READ_COARSE, 0, COARSE_BINS));
            send_item(mk(REQ_READ_COARSE, SIZE_MAX, IDX_MAX));
            send_item(mk(REQ_NOP, SIZE_MAX, IDX_MAX));
            send_item(mk(REQ_NOP, 0, 0));
            n_random = SEG_ITEMS - 24;
         end

         for (int i = 0; i < n_random; i++) begin
            if (i == n_random / 2) wait_drained();
            item.req_type = REQ_NOP;
            item.cluster_size = SIZE_W'($urandom_range(SIZE_MAX));
            item.bin_index = IDX_W'($urandom_range(IDX_MAX));
            pick = $urandom_range(99);
            if (pick < 60) begin
               item.req_type = REQ_ADD;
               case ($urandom_range(9))
                  0: item.cluster_size = SIZE_W'($urandom_range(2));
                  1, 2: item.cluster_size = SIZE_W'($urandom_range(3, 30));
                  3: item.cluster_size = near(sb.mid_edge);
                  4: item.cluster_size = near(sb.high_edge);
                  5: item.cluster_size = near(OVERFLOW_LIMIT_DEF);
                  6: item.cluster_size = SIZE_W'($urandom_range(FINE_BINS_DEF - 1));
                  7: item.cluster_size = SIZE_W'(SIZE_MAX - int'($urandom_range(15)));
                  8: item.cluster_size = SIZE_W'($urandom_range(300));
                  default: ;
               endcase
            end else if (pick < 85) begin
               item.req_type = REQ_READ_FINE;
               case ($urandom_range(3))
                  0: item.bin_index = IDX_W'($urandom_range(31));
                  1: item.bin_index = IDX_W'(near(sb.mid_edge));
                  2: item.bin_index = IDX_W'(near(OVERFLOW_LIMIT_DEF));
                  default: ;
               endcase
            end else if (pick < 97) begin
               item.req_type = REQ_READ_COARSE;
               if ($urandom_range(6) != 0) item.bin_index = IDX_W'($urandom_range(4));
            end
            send_item(item);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/wsh_pkg.sv
rtl/weighted_size_histogram.sv
rtl/wsh_checker.sv
tb/sv/weighted_size_histogram_tb.sv
